// File: rtl/pmst_pkg.sv
// Shared types and constants for the minimum spanning tree block.
package pmst_pkg;

	localparam int VTX_W = 6;
	localparam int WGT_W = 32;
	localparam int CFG_W = 7;
	localparam logic [CFG_W-1:0] VCOUNT_RST = 7'd64;

	typedef struct packed {
		logic [VTX_W-1:0]        edge_a;
		logic [VTX_W-1:0]        edge_b;
		logic signed [WGT_W-1:0] edge_weight;
		logic                    has_edge;
		logic                    last_edge;
	} edge_in_t;

	typedef struct packed {
		logic [VTX_W-1:0]        tree_low;
		logic [VTX_W-1:0]        tree_high;
		logic signed [WGT_W-1:0] tree_weight;
		logic                    tree_edge_valid;
		logic                    spanning_complete;
		logic                    edges_dropped;
		logic                    last_result;
	} tree_out_t;

endpackage

// File: rtl/pmst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pmst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/prim_minimum_spanning_tree.sv
// Top level: edge loader, Prim selection sequencer and result streamer.
//
//  channel | dir | handshake           | payload
//  in      | in  | in_valid/in_ready   | in_data  (edge_in_t)
//  out     | out | out_valid/out_ready | out_data (tree_out_t)
//  cfg     | in  | cfg_valid/cfg_ready | cfg_data (vertex_count)
//
// Loading accepts one input beat per cycle; the edge store is one RAM port.
// After the last beat each round scans the stored edges, one per cycle through
// one weight comparator, for at most vertex_count-1 rounds. Each result is then
// read in S_RD and loaded into the output register in S_LD once that is free.
// arst_n clears all control state; the edge and result RAMs are not cleared.
// in_ready is low from the last beat until the final result is loaded.
module prim_minimum_spanning_tree
	import pmst_pkg::*;
#(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES    = 256,
	parameter int WEIGHT_BITS  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  edge_in_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output tree_out_t         out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ET_W = $clog2(MAX_EDGES + 1);
	localparam int VB   = $clog2(MAX_VERTICES);
	localparam int EW   = 2 * VTX_W + WEIGHT_BITS;
	localparam int CW   = (WEIGHT_BITS > WGT_W) ? WEIGHT_BITS : WGT_W;
	localparam logic signed [WEIGHT_BITS-1:0] W_TOP = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
	localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

	typedef enum logic [6:0] {
		S_LOAD  = 7'b0000001,
		S_ROUND = 7'b0000010,
		S_SCAN  = 7'b0000100,
		S_PICK  = 7'b0001000,
		S_FIN   = 7'b0010000,
		S_RD    = 7'b0100000,
		S_LD    = 7'b1000000
	} state_t;

	state_t                   state_q;
	logic [CFG_W-1:0]         vcount_q;
	logic [ET_W-1:0]          edge_total_q;
	logic [ET_W-1:0]          issue_q;
	logic [MAX_VERTICES-1:0]  visited_q;
	logic [VB-1:0]            tree_count_q;
	logic [VB-1:0]            emit_q;
	logic                     overflow_q;
	logic                     rv_s1;
	logic                     found_q;
	logic                     done_q;
	logic                     empty_q;
	logic signed [WEIGHT_BITS-1:0] best_q;
	logic [VTX_W-1:0]         pick_lo_q;
	logic [VTX_W-1:0]         pick_hi_q;
	logic                     out_valid_q;
	tree_out_t                out_q;

	logic [CFG_W-1:0]         nv;
	logic [CFG_W-1:0]         tc_next;
	logic                     in_acc;
	logic                     edge_ok;
	logic                     full;
	logic [VTX_W-1:0]         ld_lo;
	logic [VTX_W-1:0]         ld_hi;
	logic signed [CW-1:0]     w_ext;
	logic signed [WEIGHT_BITS-1:0] w_sat;
	logic                     e_we;
	logic                     e_re;
	logic [EW-1:0]            e_rdata;
	logic [VTX_W-1:0]         rd_lo;
	logic [VTX_W-1:0]         rd_hi;
	logic signed [WEIGHT_BITS-1:0] rd_w;
	logic                     crosses;
	logic                     r_we;
	logic                     r_re;
	logic [EW-1:0]            r_rdata;
	logic signed [WEIGHT_BITS-1:0] res_w;
	logic signed [CW-1:0]     res_w_ext;
	logic                     out_free;
	logic                     last_res;

	assign nv       = (vcount_q > CFG_W'(MAX_VERTICES)) ? CFG_W'(MAX_VERTICES) : vcount_q;
	assign tc_next  = CFG_W'(tree_count_q) + CFG_W'(1);
	assign in_ready = (state_q == S_LOAD);
	assign in_acc   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign full     = (edge_total_q == ET_W'(MAX_EDGES));
	assign edge_ok  = in_data.has_edge && (CFG_W'(in_data.edge_a) < nv)
		&& (CFG_W'(in_data.edge_b) < nv) && (in_data.edge_a != in_data.edge_b);
	assign ld_lo    = (in_data.edge_a < in_data.edge_b) ? in_data.edge_a : in_data.edge_b;
	assign ld_hi    = (in_data.edge_a < in_data.edge_b) ? in_data.edge_b : in_data.edge_a;

	// saturate the incoming weight into the stored signed range
	always_comb begin
		w_ext = CW'(in_data.edge_weight);
		if (w_ext > CW'(W_TOP)) begin
			w_sat = W_TOP;
		end else if (w_ext < CW'(W_MIN)) begin
			w_sat = W_MIN;
		end else begin
			w_sat = w_ext[WEIGHT_BITS-1:0];
		end
	end

	assign e_we = in_acc && edge_ok && !full;
	assign e_re = (state_q == S_SCAN) && (issue_q < edge_total_q);

	pmst_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_EDGES),
		.AW   (EA_W)
	) u_edge_ram (
		.clk  (clk),
		.we   (e_we),
		.waddr(edge_total_q[EA_W-1:0]),
		.wdata({ld_lo, ld_hi, w_sat}),
		.re   (e_re),
		.raddr(issue_q[EA_W-1:0]),
		.rdata(e_rdata)
	);

	assign rd_lo   = e_rdata[EW-1 -: VTX_W];
	assign rd_hi   = e_rdata[EW-VTX_W-1 -: VTX_W];
	assign rd_w    = e_rdata[WEIGHT_BITS-1:0];
	assign crosses = visited_q[rd_lo[VB-1:0]] != visited_q[rd_hi[VB-1:0]];

	assign r_we = (state_q == S_PICK) && found_q;
	assign r_re = (state_q == S_RD);

	pmst_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_VERTICES),
		.AW   (VB)
	) u_result_ram (
		.clk  (clk),
		.we   (r_we),
		.waddr(tree_count_q),
		.wdata({pick_lo_q, pick_hi_q, best_q}),
		.re   (r_re),
		.raddr(emit_q),
		.rdata(r_rdata)
	);

	assign res_w     = r_rdata[WEIGHT_BITS-1:0];
	assign res_w_ext = CW'(res_w);
	assign out_free  = !out_valid_q || out_ready;
	assign last_res  = empty_q || (emit_q == tree_count_q - VB'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			vcount_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			edge_total_q <= '0;
			issue_q      <= '0;
			visited_q    <= '0;
			tree_count_q <= '0;
			emit_q       <= '0;
			overflow_q   <= 1'b0;
			rv_s1        <= 1'b0;
			found_q      <= 1'b0;
			done_q       <= 1'b0;
			empty_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// in S_LD a taken beat is replaced by the next one below
			if (out_valid_q && out_ready && (state_q != S_LD)) begin
				out_valid_q <= 1'b0;
			end
			// comparator sees the edge read in the previous cycle
			if (rv_s1 && crosses && (rd_w < best_q)) begin
				found_q <= 1'b1;
			end
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (in_data.has_edge && edge_ok) begin
							if (full) begin
								overflow_q <= 1'b1;
							end else begin
								edge_total_q <= edge_total_q + ET_W'(1);
							end
						end
						if (in_data.last_edge) begin
							if (nv != '0) begin
								visited_q[0] <= 1'b1;
							end
							state_q <= S_ROUND;
						end
					end
				end
				S_ROUND: begin
					issue_q <= '0;
					found_q <= 1'b0;
					rv_s1   <= 1'b0;
					if ((nv != '0) && (tc_next < nv) && (edge_total_q != '0)) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_SCAN: begin
					if (issue_q < edge_total_q) begin
						issue_q <= issue_q + ET_W'(1);
						rv_s1   <= 1'b1;
					end else begin
						rv_s1 <= 1'b0;
						if (!rv_s1) begin
							state_q <= S_PICK;
						end
					end
				end
				S_PICK: begin
					if (found_q) begin
						visited_q[pick_lo_q[VB-1:0]] <= 1'b1;
						visited_q[pick_hi_q[VB-1:0]] <= 1'b1;
						tree_count_q <= tree_count_q + VB'(1);
						state_q      <= S_ROUND;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					done_q <= (nv != '0) && (tc_next == nv);
					emit_q <= '0;
					if (tree_count_q == '0) begin
						empty_q <= 1'b1;
						state_q <= S_LD;
					end else begin
						empty_q <= 1'b0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_LD;
				end
				S_LD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (last_res) begin
							edge_total_q <= '0;
							visited_q    <= '0;
							tree_count_q <= '0;
							overflow_q   <= 1'b0;
							state_q      <= S_LOAD;
						end else begin
							emit_q  <= emit_q + VB'(1);
							state_q <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// payload registers: running minimum and output beat
	always_ff @(posedge clk) begin
		if (state_q == S_ROUND) begin
			best_q <= W_TOP;
		end else if (rv_s1 && crosses && (rd_w < best_q)) begin
			best_q    <= rd_w;
			pick_lo_q <= rd_lo;
			pick_hi_q <= rd_hi;
		end
		if ((state_q == S_LD) && out_free) begin
			out_q.tree_low          <= empty_q ? '0 : r_rdata[EW-1 -: VTX_W];
			out_q.tree_high         <= empty_q ? '0 : r_rdata[EW-VTX_W-1 -: VTX_W];
			out_q.tree_weight       <= empty_q ? '0 : res_w_ext[WGT_W-1:0];
			out_q.tree_edge_valid   <= !empty_q;
			out_q.spanning_complete <= done_q;
			out_q.edges_dropped     <= overflow_q;
			out_q.last_result       <= last_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: rtl/pmst_chk.sv
// Port-level checker for the spanning tree block, bound to the top level.
module pmst_chk
	import pmst_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input edge_in_t          in_data,
	input logic              out_valid,
	input logic              out_ready,
	input tree_out_t         out_data
);

	// a waiting output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed before it was taken");

	// the final beat of a graph starts the compute phase
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.last_edge |=> !in_ready)
		else $error("input taken right after last beat");

	// no new input while earlier results of a graph are still streaming
	a_stream_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last_result |-> !in_ready)
		else $error("input ready mid result stream");

	// an empty result is always the only one
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.tree_edge_valid |-> out_data.last_result)
		else $error("empty result not marked last");

	// tree edges come out ordered low then high
	a_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.tree_edge_valid |-> out_data.tree_low < out_data.tree_high)
		else $error("tree edge endpoints not ordered");

endmodule

bind prim_minimum_spanning_tree pmst_chk u_pmst_chk (.*);
